// ===== hw/rtl/evm_pkg.sv =====
package evm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ZW = 33;
    localparam int XW = 34;

    localparam logic signed [ZW-1:0] ANG_PI      = 33'sd843314857;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 33'sd421657428;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 33'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

    function automatic logic signed [ZW-1:0] atan_q28(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0: r = 33'sd210828714;
            1: r = 33'sd124459457;
            2: r = 33'sd65760959;
            3: r = 33'sd33381290;
            4: r = 33'sd16755422;
            5: r = 33'sd8385879;
            6: r = 33'sd4193963;
            7: r = 33'sd2097109;
            8: r = 33'sd1048571;
            9: r = 33'sd524287;
            default: r = ZW'(64'sd1 << (28 - i));
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_unit(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd16384)
            r = 16'sd16384;
        else if (v < -64'sd16384)
            r = -16'sd16384;
        else
            r = 16'(v);
        return r;
    endfunction

endpackage

// ===== hw/rtl/euler_view_matrix.sv =====
// Camera view matrix from a Y-X-Z Euler pose. One request is taken per cycle (busy is
// always low). Its result is on the outputs with done high for one cycle. NS is
// CORDIC_STEPS capped at 24. The request passes the reduction stage, then the three
// CORDIC lanes, one iteration stage per step. Product, sum, dot-product and output
// stages follow. The receiver cannot stall: each result must be taken in its
// done cycle.
module euler_view_matrix
    import evm_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] angle_pitch,
    input  logic signed [15:0] angle_yaw,
    input  logic signed [15:0] angle_roll,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               done,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z,
    output logic signed [15:0] fwd_x,
    output logic signed [15:0] fwd_y,
    output logic signed [15:0] fwd_z,
    output logic signed [31:0] offset_u,
    output logic signed [31:0] offset_v,
    output logic signed [31:0] offset_w
);

    localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } lane_t;

    assign busy = 1'b0;

    // angle reduction into [-pi/2, pi/2]
    function automatic lane_t reduce(input logic signed [15:0] a);
        lane_t r;
        logic signed [ZW-1:0] z;
        z = ZW'(a) <<< 16;
        r.flip = 1'b0;
        if (z > ANG_PI)
            z = z - ANG_TWO_PI;
        else if (z < -ANG_PI)
            z = z + ANG_TWO_PI;
        if (z > ANG_HALF_PI)
        begin
            z = z - ANG_PI;
            r.flip = 1'b1;
        end
        else if (z < -ANG_HALF_PI)
        begin
            z = z + ANG_PI;
            r.flip = 1'b1;
        end
        r.x = GAIN_Q30;
        r.y = '0;
        r.z = z;
        return r;
    endfunction

    function automatic lane_t rot(input lane_t a, input int i);
        lane_t r;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        r = a;
        if (!a.z[ZW-1])
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_q28(i);
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_q28(i);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] fin(input logic signed [XW-1:0] v, input logic f);
        logic signed [XW:0] t;
        t = f ? -(XW+1)'(v) : (XW+1)'(v);
        t = (t + (XW+1)'(32768)) >>> 16;
        return clamp_unit(64'(t));
    endfunction

    // stage 0: reduction; stages 1..NS: CORDIC iterations
    logic  [NS:0]  vld_reg;
    lane_t         ln_reg [3][NS+1];
    logic signed [31:0] p_reg [NS+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NS-1:0], start};
    end

    always_ff @(posedge clk)
    begin
        ln_reg[0][0] <= reduce(angle_yaw);
        ln_reg[1][0] <= reduce(angle_pitch);
        ln_reg[2][0] <= reduce(angle_roll);
        p_reg[0][0] <= pos_x;
        p_reg[0][1] <= pos_y;
        p_reg[0][2] <= pos_z;
        for (int s = 0; s < NS; s++)
        begin
            for (int l = 0; l < 3; l++)
                ln_reg[l][s+1] <= rot(ln_reg[l][s], s);
            p_reg[s+1] <= p_reg[s];
        end
    end

    // stage A: cos/sin rounded, and pairwise products (Q.28)
    logic signed [15:0] c1, s1, c2, s2, c3, s3;
    assign c1 = fin(ln_reg[0][NS].x, ln_reg[0][NS].flip);
    assign s1 = fin(ln_reg[0][NS].y, ln_reg[0][NS].flip);
    assign c2 = fin(ln_reg[1][NS].x, ln_reg[1][NS].flip);
    assign s2 = fin(ln_reg[1][NS].y, ln_reg[1][NS].flip);
    assign c3 = fin(ln_reg[2][NS].x, ln_reg[2][NS].flip);
    assign s3 = fin(ln_reg[2][NS].y, ln_reg[2][NS].flip);

    logic               a_vld_reg;
    logic signed [31:0] c1c3_reg, s1s3_reg, c3s1_reg, c1s3_reg, c2s3_reg, c2c3_reg;
    logic signed [31:0] c2s1_reg, c1c2_reg;
    logic signed [15:0] s2a_reg;
    logic signed [31:0] pa_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        c1c3_reg <= c1 * c3;
        s1s3_reg <= s1 * s3;
        c3s1_reg <= c3 * s1;
        c1s3_reg <= c1 * s3;
        c2s3_reg <= c2 * s3;
        c2c3_reg <= c2 * c3;
        c2s1_reg <= c2 * s1;
        c1c2_reg <= c1 * c2;
        s2a_reg  <= s2;
        pa_reg   <= p_reg[NS];
    end

    // stage B: triple products (Q.42)
    logic               b_vld_reg;
    logic signed [47:0] t_s1s3s2_reg, t_c1s3s2_reg, t_c3s1s2_reg, t_c1c3s2_reg;
    logic signed [31:0] c1c3b_reg, s1s3b_reg, c3s1b_reg, c1s3b_reg;
    logic signed [31:0] c2s3b_reg, c2c3b_reg, c2s1b_reg, c1c2b_reg;
    logic signed [15:0] s2b_reg;
    logic signed [31:0] pb_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        t_s1s3s2_reg <= 48'(s1s3_reg) * 48'(s2a_reg);
        t_c1s3s2_reg <= 48'(c1s3_reg) * 48'(s2a_reg);
        t_c3s1s2_reg <= 48'(c3s1_reg) * 48'(s2a_reg);
        t_c1c3s2_reg <= 48'(c1c3_reg) * 48'(s2a_reg);
        c1c3b_reg <= c1c3_reg;
        s1s3b_reg <= s1s3_reg;
        c3s1b_reg <= c3s1_reg;
        c1s3b_reg <= c1s3_reg;
        c2s3b_reg <= c2s3_reg;
        c2c3b_reg <= c2c3_reg;
        c2s1b_reg <= c2s1_reg;
        c1c2b_reg <= c1c2_reg;
        s2b_reg   <= s2a_reg;
        pb_reg    <= pa_reg;
    end

    // stage C: basis sums rounded to Q.14
    function automatic logic signed [15:0] r42(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = (v + (50'sd1 <<< 27)) >>> 28;
        return clamp_unit(64'(t));
    endfunction

    function automatic logic signed [15:0] r28(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = (33'(v) + 33'sd8192) >>> 14;
        return clamp_unit(64'(t));
    endfunction

    function automatic logic signed [49:0] q42(input logic signed [31:0] v);
        return 50'(v) <<< 14;
    endfunction

    logic               c_vld_reg;
    logic signed [15:0] bas_reg [9];
    logic signed [31:0] pc_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        bas_reg[0] <= r42(q42(c1c3b_reg) + 50'(t_s1s3s2_reg));
        bas_reg[1] <= r28(c2s3b_reg);
        bas_reg[2] <= r42(50'(t_c1s3s2_reg) - q42(c3s1b_reg));
        bas_reg[3] <= r42(50'(t_c3s1s2_reg) - q42(c1s3b_reg));
        bas_reg[4] <= r28(c2c3b_reg);
        bas_reg[5] <= r42(50'(t_c1c3s2_reg) + q42(s1s3b_reg));
        bas_reg[6] <= r28(c2s1b_reg);
        bas_reg[7] <= -s2b_reg;
        bas_reg[8] <= r28(c1c2b_reg);
        pc_reg     <= pb_reg;
    end

    // stage D: dot-product terms (16 x 32)
    logic               d_vld_reg;
    logic signed [47:0] prod_reg [9];
    logic signed [15:0] basd_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            prod_reg[k] <= 48'(bas_reg[k]) * 48'(pc_reg[k % 3]);
        basd_reg <= bas_reg;
    end

    // stage E: sum, negate, round, saturate
    function automatic logic signed [31:0] offs(input logic signed [47:0] a,
                                                input logic signed [47:0] b,
                                                input logic signed [47:0] c);
        logic signed [50:0] t;
        logic signed [31:0] r;
        t = -(51'(a) + 51'(b) + 51'(c));
        t = (t + 51'sd8192) >>> 14;
        if (t > 51'sd2147483647)
            r = 32'sh7fffffff;
        else if (t < -51'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(t);
        return r;
    endfunction

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        right_x  <= basd_reg[0];
        right_y  <= basd_reg[1];
        right_z  <= basd_reg[2];
        up_x     <= basd_reg[3];
        up_y     <= basd_reg[4];
        up_z     <= basd_reg[5];
        fwd_x    <= basd_reg[6];
        fwd_y    <= basd_reg[7];
        fwd_z    <= basd_reg[8];
        offset_u <= offs(prod_reg[0], prod_reg[1], prod_reg[2]);
        offset_v <= offs(prod_reg[3], prod_reg[4], prod_reg[5]);
        offset_w <= offs(prod_reg[6], prod_reg[7], prod_reg[8]);
    end

    assign done = done_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |=> done) else $error("done lost");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !d_vld_reg |=> !done) else $error("spurious done");
    a_stage_chain: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] |=> a_vld_reg) else $error("valid lost after cordic");
    a_fwd_y: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |-> bas_reg[7] >= -16'sd16384 && bas_reg[7] <= 16'sd16384)
        else $error("fwd_y out of range");

endmodule

// ===== tb/tb_euler_view_matrix.sv =====
`timescale 1ns / 100ps

module tb_euler_view_matrix;
    import evm_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int LATENCY = STEPS + 5;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
        logic signed [31:0] ou, ov, ow;
    } view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] angle_pitch = '0, angle_yaw = '0, angle_roll = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic done;
    logic signed [15:0] right_x, right_y, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z;
    logic signed [31:0] offset_u, offset_v, offset_w;

    pose_t pose_q[$];
    view_t view_q[$];
    int idle_pct = 0;
    int errors = 0;
    int n_sent = 0;
    int n_seen = 0;

    euler_view_matrix i_dut (.*);

    always #5 clk = ~clk;

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] unit_clamp(logic signed [63:0] v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    function automatic logic signed [63:0] arctan_q28(int i);
        logic signed [63:0] tbl [10] = '{210828714, 124459457, 65760959, 33381290,
            16755422, 8385879, 4193963, 2097109, 1048571, 524287};
        if (i < 10)
            return tbl[i];
        return 64'sd1 <<< (28 - i);
    endfunction

    function automatic void trig(input logic signed [15:0] a, output logic signed [63:0] c,
                                 output logic signed [63:0] s);
        logic signed [63:0] z, x, y, dx, dy;
        bit flip;
        z = 64'(a) * 65536;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 843314857)
            z -= 1686629713;
        else if (z < -843314857)
            z += 1686629713;
        if (z > 421657428)
        begin
            z -= 843314857;
            flip = 1;
        end
        else if (z < -421657428)
        begin
            z += 843314857;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_q28(i);
            end
            else
            begin
                x += dx; y -= dy; z += arctan_q28(i);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = unit_clamp(floor_shift(x + 32768, 16));
        s = unit_clamp(floor_shift(y + 32768, 16));
    endfunction

    function automatic logic signed [63:0] rnd42(logic signed [63:0] v);
        return unit_clamp(floor_shift(v + (64'sd1 <<< 27), 28));
    endfunction

    function automatic logic signed [63:0] rnd28(logic signed [63:0] v);
        return unit_clamp(floor_shift(v + 8192, 14));
    endfunction

    function automatic logic signed [31:0] neg_dot(logic signed [63:0] b0, b1, b2,
                                                   logic signed [63:0] p0, p1, p2);
        logic signed [63:0] r;
        r = floor_shift(-(b0 * p0 + b1 * p1 + b2 * p2) + 8192, 14);
        if (r > 64'sd2147483647)
            return 32'sh7fffffff;
        if (r < -64'sd2147483648)
            return 32'sh80000000;
        return 32'(r);
    endfunction

    function automatic view_t view_of(pose_t p);
        logic signed [63:0] c1, s1, c2, s2, c3, s3, u0, u1, u2, v0, v1, v2, w0, w1, w2;
        view_t r;
        trig(p.yaw, c1, s1);
        trig(p.pitch, c2, s2);
        trig(p.roll, c3, s3);
        u0 = rnd42(c1 * c3 * 16384 + s1 * s2 * s3);
        u1 = rnd28(c2 * s3);
        u2 = rnd42(c1 * s2 * s3 - c3 * s1 * 16384);
        v0 = rnd42(c3 * s1 * s2 - c1 * s3 * 16384);
        v1 = rnd28(c2 * c3);
        v2 = rnd42(c1 * c3 * s2 + s1 * s3 * 16384);
        w0 = rnd28(c2 * s1);
        w1 = -s2;
        w2 = rnd28(c1 * c2);
        r.rx = 16'(u0); r.ry = 16'(u1); r.rz = 16'(u2);
        r.ux = 16'(v0); r.uy = 16'(v1); r.uz = 16'(v2);
        r.fx = 16'(w0); r.fy = 16'(w1); r.fz = 16'(w2);
        r.ou = neg_dot(u0, u1, u2, p.px, p.py, p.pz);
        r.ov = neg_dot(v0, v1, v2, p.px, p.py, p.pz);
        r.ow = neg_dot(w0, w1, w2, p.px, p.py, p.pz);
        return r;
    endfunction

    // driver: start held high across back-to-back requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                view_q.push_back(view_of({angle_pitch, angle_yaw, angle_roll,
                                          pos_x, pos_y, pos_z}));
                n_sent++;
            end
            if ((!start || !busy) && pose_q.size() > 0
                && $urandom_range(99) >= idle_pct)
            begin
                pose_t p;
                p = pose_q.pop_front();
                start <= 1'b1;
                angle_pitch <= p.pitch; angle_yaw <= p.yaw; angle_roll <= p.roll;
                pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    task automatic cmp(string name, logic signed [31:0] e, logic signed [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            view_t e;
            if (view_q.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                e = view_q.pop_front();
                n_seen++;
                cmp("right_x", e.rx, right_x); cmp("right_y", e.ry, right_y);
                cmp("right_z", e.rz, right_z); cmp("up_x", e.ux, up_x);
                cmp("up_y", e.uy, up_y); cmp("up_z", e.uz, up_z);
                cmp("fwd_x", e.fx, fwd_x); cmp("fwd_y", e.fy, fwd_y);
                cmp("fwd_z", e.fz, fwd_z); cmp("offset_u", e.ou, offset_u);
                cmp("offset_v", e.ov, offset_v); cmp("offset_w", e.ow, offset_w);
            end
        end
    end

    function automatic pose_t random_pose();
        pose_t p;
        int k;
        p = {16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom};
        k = $urandom_range(9);
        // half of the poses get moderate translations, the rest full-range
        if (k < 5)
        begin
            p.px = 32'(signed'($urandom_range(2000000))) - 1000000;
            p.py = 32'(signed'($urandom_range(2000000))) - 1000000;
            p.pz = 32'(signed'($urandom_range(2000000))) - 1000000;
        end
        if (k == 9)
        begin
            p.pitch = 16'($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
            p.yaw = 16'($urandom_range(1)) ? 16'sd12868 : -16'sd12868;
        end
        return p;
    endfunction

    task automatic drain();
        while (pose_q.size() > 0 || start || view_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int angs [9] = '{0, 32767, -32768, 6434, -6434, 12868, -12868, 12869, -12869};
        int pidle [4] = '{0, 72, 0, 27};
        pose_t p;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed: angle extremes and quadrant edges, translation extremes
        foreach (angs[i])
        begin
            p = '{16'(angs[i]), 16'(angs[(i + 3) % 9]), 16'(angs[(i + 5) % 9]),
                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
            pose_q.push_back(p);
            p.pitch = 16'(angs[(i + 1) % 9]);
            p.px = 32'sh80000000; p.py = 32'sh7fffffff; p.pz = 32'sh80000000;
            pose_q.push_back(p);
        end
        pose_q.push_back('0);
        pose_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff,
                           32'sh7fffffff, 32'sh7fffffff});
        pose_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000,
                           32'sh80000000, 32'sh80000000});
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = pidle[ph];
            for (int i = 0; i < 285; i++)
                pose_q.push_back(random_pose());
            drain();
        end
        repeat (LATENCY + 5) @(posedge clk);
        $display("%0d poses sent, %0d view matrices checked, sender idle 0/72/0/27 percent",
                 n_sent, n_seen);
        if (errors == 0 && view_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
